>>> src/spq_pkg.sv
// Package with the shared types and codes of the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

	// Operation codes carried on func.
	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	// Result status codes.
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	// Fixed field widths.
	localparam int unsigned DATA_W = 32;
	localparam int unsigned OCC_W  = 9;

	// One stored entry of the chain.
	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] prio;
	} entry_t;

	// Per-cycle command broadcast to every cell.
	typedef struct packed {
		logic enq;
		logic deq;
	} cell_ctrl_t;

endpackage

>>> src/spq_cell.sv
// One cell of the sorted chain: holds a single entry, ordered highest priority first.
`timescale 1ns / 1ps

module spq_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  spq_pkg::cell_ctrl_t               ctrl,
	input  logic signed [spq_pkg::DATA_W-1:0] new_value,
	input  logic signed [spq_pkg::DATA_W-1:0] new_priority,
	input  spq_pkg::entry_t                   up_entry,
	input  logic                              up_keep,
	input  spq_pkg::entry_t                   down_entry,
	output spq_pkg::entry_t                   entry,
	output logic                              keep
);

	logic                              valid_q;
	logic signed [spq_pkg::DATA_W-1:0] value_q;
	logic signed [spq_pkg::DATA_W-1:0] priority_q;
	logic                              load;
	spq_pkg::entry_t                   next_entry;

	// A cell keeps its entry on an insert when it outranks the new one strictly,
	// so the new entry lands ahead of any stored entry of equal priority.
	assign keep = valid_q && (priority_q > new_priority);

	// Choose what the cell takes this cycle: the new entry, the neighbour above
	// shifting down, or the neighbour below moving up on a removal.
	always_comb begin
		load       = 1'b0;
		next_entry = up_entry;
		if (ctrl.enq && !keep) begin
			load = 1'b1;
			if (up_keep) begin
				next_entry.valid = 1'b1;
				next_entry.value = new_value;
				next_entry.prio  = new_priority;
			end else begin
				next_entry = up_entry;
			end
		end else if (ctrl.deq) begin
			load       = 1'b1;
			next_entry = down_entry;
		end
	end

	// Occupancy flag of the cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= next_entry.valid;
		end
	end

	// Entry payload.
	always_ff @(posedge clk) begin
		if (load) begin
			value_q    <= next_entry.value;
			priority_q <= next_entry.prio;
		end
	end

	assign entry.valid = valid_q;
	assign entry.value = value_q;
	assign entry.prio  = priority_q;

endmodule

>>> src/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: a chain of entry cells and the result register.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid, in_ready, func, item_value,    | to block
//           | item_priority                            |
//   out     | out_valid, out_ready, data_out, status,  | from block
//           | occupancy_out                            |
//
// One beat is accepted per cycle while the result register is empty or being read; its result
// stands in the output register on the next cycle. Every cell compares its priority with the
// incoming one and shifts in the same cycle.
// Reset clears the cell valid flags and the count at once; there is no clearing pass.
// A stalled result holds the input side only until out_ready returns or the beat is taken.
`timescale 1ns / 1ps

module sorted_priority_queue_core #(
	parameter int unsigned DEPTH = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               func,
	input  logic signed [spq_pkg::DATA_W-1:0]  item_value,
	input  logic signed [spq_pkg::DATA_W-1:0]  item_priority,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [spq_pkg::DATA_W-1:0]  data_out,
	output logic [1:0]                         status,
	output logic [spq_pkg::OCC_W-1:0]          occupancy_out
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic                               accept;
	logic                               is_full;
	logic                               is_empty;
	logic                               enq_do;
	logic                               deq_do;
	logic [CNT_W-1:0]                   count_q;
	logic [CNT_W-1:0]                   count_next;
	logic [CNT_W+spq_pkg::OCC_W-1:0]    count_ext;
	spq_pkg::cell_ctrl_t                ctrl;
	spq_pkg::entry_t                    cell_entry [DEPTH];
	logic                               cell_keep  [DEPTH];
	logic                               out_valid_q;
	logic signed [spq_pkg::DATA_W-1:0]  data_q;
	logic [1:0]                         status_q;
	logic [spq_pkg::OCC_W-1:0]          occ_q;

	// Handshake and operation decode.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);
	assign enq_do   = accept && (func == spq_pkg::FUNC_ENQ) && !is_full;
	assign deq_do   = accept && (func == spq_pkg::FUNC_DEQ) && !is_empty;
	assign ctrl.enq = enq_do;
	assign ctrl.deq = deq_do;

	// Chain of cells, cell 0 holding the entry served next.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_pkg::entry_t up_entry;
		spq_pkg::entry_t down_entry;
		logic            up_keep;

		if (i == 0) begin : g_head
			assign up_entry = '0;
			assign up_keep  = 1'b1;
		end else begin : g_body
			assign up_entry = cell_entry[i-1];
			assign up_keep  = cell_keep[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign down_entry = '0;
		end else begin : g_link
			assign down_entry = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.new_value    (item_value),
			.new_priority (item_priority),
			.up_entry     (up_entry),
			.up_keep      (up_keep),
			.down_entry   (down_entry),
			.entry        (cell_entry[i]),
			.keep         (cell_keep[i])
		);
	end

	// Entry count after this beat.
	always_comb begin
		count_next = count_q;
		if (enq_do) begin
			count_next = count_q + CNT_W'(1);
		end else if (deq_do) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	assign count_ext = {{spq_pkg::OCC_W{1'b0}}, count_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	// Result register: valid flag under reset, payload loaded on each accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			occ_q <= count_ext[spq_pkg::OCC_W-1:0];
			if (func == spq_pkg::FUNC_ENQ) begin
				data_q   <= '0;
				status_q <= is_full ? spq_pkg::STATUS_FULL : spq_pkg::STATUS_OK;
			end else if (is_empty) begin
				data_q   <= '0;
				status_q <= spq_pkg::STATUS_EMPTY;
			end else begin
				data_q   <= cell_entry[0].value;
				status_q <= spq_pkg::STATUS_OK;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign data_out      = data_q;
	assign status        = status_q;
	assign occupancy_out = occ_q;

endmodule

>>> src/spq_checker.sv
// Port-level checker for the sorted priority queue, bound to the top level.
`timescale 1ns / 1ps

module spq_checker #(
	parameter int unsigned DEPTH = 256
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [spq_pkg::DATA_W-1:0] data_out,
	input logic [1:0]                        status,
	input logic [spq_pkg::OCC_W-1:0]         occupancy_out
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W+spq_pkg::OCC_W-1:0] DEPTH_EXT = (CNT_W + spq_pkg::OCC_W)'(DEPTH);

	// A refused or empty result never carries data.
	a_quiet_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == spq_pkg::STATUS_FULL || status == spq_pkg::STATUS_EMPTY)
		|-> data_out == '0)
		else $error("data_out not zero on a full or empty result");

	// An empty dequeue reports an empty queue.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == spq_pkg::STATUS_EMPTY |-> occupancy_out == '0)
		else $error("empty status with non-zero occupancy");

	// A dropped enqueue reports a full queue.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == spq_pkg::STATUS_FULL
		|-> occupancy_out == DEPTH_EXT[spq_pkg::OCC_W-1:0])
		else $error("full status with occupancy below depth");

	// An accepted beat shows its result on the next cycle.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no result after an accepted beat");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_out) && $stable(status))
		else $error("stalled result changed");

endmodule

bind sorted_priority_queue_core spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.data_out      (data_out),
	.status        (status),
	.occupancy_out (occupancy_out)
);

>>> tb/spq_result_checker.sv
// Checker for the sorted priority queue: predicts each result beat and compares it with the block.
`timescale 1ns / 1ps

module spq_result_checker #(
	parameter int unsigned CAPACITY = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic                              func,
	input  logic signed [spq_pkg::DATA_W-1:0] item_value,
	input  logic signed [spq_pkg::DATA_W-1:0] item_priority,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic signed [spq_pkg::DATA_W-1:0] data_out,
	input  logic [1:0]                        status,
	input  logic [spq_pkg::OCC_W-1:0]         occupancy_out,
	output int unsigned                       mismatches,
	output int unsigned                       outstanding
);

	// One predicted result beat.
	typedef struct packed {
		logic signed [spq_pkg::DATA_W-1:0] data;
		logic [1:0]                        status;
		logic [spq_pkg::OCC_W-1:0]         occupancy;
	} queue_result_t;

	// Shadow copy of the queue, kept in ascending order of signed priority.
	logic signed [spq_pkg::DATA_W-1:0] slot_value [CAPACITY];
	logic signed [spq_pkg::DATA_W-1:0] slot_rank  [CAPACITY];
	int unsigned                       held;

	queue_result_t awaited [$];

	// Apply one accepted operation to the shadow queue and record the result it must give.
	task automatic predict_beat(input logic op, input logic signed [spq_pkg::DATA_W-1:0] val,
			input logic signed [spq_pkg::DATA_W-1:0] pri);
		queue_result_t want;
		int unsigned   k;
		want.data   = '0;
		want.status = spq_pkg::STATUS_OK;
		if (op == spq_pkg::FUNC_ENQ) begin
			if (held >= CAPACITY) begin
				want.status = spq_pkg::STATUS_FULL;
			end else begin
				// Walk down past every entry of strictly higher priority, so that
				// equal priorities end up above the older entries.
				k = held;
				while (k > 0 && $signed(slot_rank[k-1]) > $signed(pri)) begin
					slot_value[k] = slot_value[k-1];
					slot_rank[k]  = slot_rank[k-1];
					k--;
				end
				slot_value[k] = val;
				slot_rank[k]  = pri;
				held++;
			end
		end else begin
			if (held == 0) begin
				want.status = spq_pkg::STATUS_EMPTY;
			end else begin
				held--;
				want.data = slot_value[held];
			end
		end
		want.occupancy = held[spq_pkg::OCC_W-1:0];
		awaited.push_back(want);
	endtask

	// Compare one result beat with the oldest prediction.
	task automatic check_beat();
		queue_result_t want;
		if (awaited.size() == 0) begin
			$error("result beat with no prediction pending: data_out %0d status %0d occupancy %0d",
				data_out, status, occupancy_out);
			mismatches++;
		end else begin
			want = awaited.pop_front();
			if (data_out !== want.data) begin
				$error("data_out mismatch: expected %0d, got %0d", want.data, data_out);
				mismatches++;
			end
			if (status !== want.status) begin
				$error("status mismatch: expected %0d, got %0d", want.status, status);
				mismatches++;
			end
			if (occupancy_out !== want.occupancy) begin
				$error("occupancy_out mismatch: expected %0d, got %0d",
					want.occupancy, occupancy_out);
				mismatches++;
			end
		end
	endtask

	// Watch both channels; the input beat is handled first in case a result appears at once.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held        = 0;
			mismatches  = 0;
			outstanding = 0;
			awaited.delete();
		end else begin
			if (in_valid && in_ready)
				predict_beat(func, item_value, item_priority);
			if (out_valid && out_ready)
				check_beat();
			outstanding = awaited.size();
		end
	end

endmodule

>>> tb/sorted_priority_queue_core_test.sv
// Top of the sorted priority queue testbench: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps

module sorted_priority_queue_core_test;

	localparam int unsigned QUEUE_DEPTH   = 256;
	localparam int unsigned HOLD_CYCLES   = 64;
	localparam int unsigned STALL_LIMIT   = 2000;
	localparam int unsigned SETTLE_CYCLES = 4;

	logic                              clk           = 1'b0;
	logic                              arst_n        = 1'b0;
	logic                              in_valid      = 1'b0;
	logic                              in_ready;
	logic                              func          = spq_pkg::FUNC_ENQ;
	logic signed [spq_pkg::DATA_W-1:0] item_value    = '0;
	logic signed [spq_pkg::DATA_W-1:0] item_priority = '0;
	logic                              out_valid;
	logic                              out_ready     = 1'b0;
	logic signed [spq_pkg::DATA_W-1:0] data_out;
	logic [1:0]                        status;
	logic [spq_pkg::OCC_W-1:0]         occupancy_out;

	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned hold_token  = 0;
	int unsigned hold_seen   = 0;
	int unsigned hold_left   = 0;
	int unsigned quiet_cycles;
	int unsigned mismatches;
	int unsigned outstanding;

	sorted_priority_queue_core #(
		.DEPTH(QUEUE_DEPTH)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.item_value   (item_value),
		.item_priority(item_priority),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.data_out     (data_out),
		.status       (status),
		.occupancy_out(occupancy_out)
	);

	spq_result_checker #(
		.CAPACITY(QUEUE_DEPTH)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.item_value   (item_value),
		.item_priority(item_priority),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.data_out     (data_out),
		.status       (status),
		.occupancy_out(occupancy_out),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	always #4 clk = ~clk;

	// Receiver: random back-pressure, plus a long hold-off whenever a new one is requested.
	always @(negedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Watchdog: give up when no beat moves on either channel for too long.
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("sorted_priority_queue_core verification failed");
		$finish;
	end

	// Offer one beat, with random gaps ahead of it, and wait until it is taken.
	task automatic offer_beat(input logic op, input logic signed [spq_pkg::DATA_W-1:0] val,
			input logic signed [spq_pkg::DATA_W-1:0] pri);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		func          <= op;
		item_value    <= val;
		item_priority <= pri;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Stop offering and wait until every predicted result has come back.
	task automatic pause_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// Priorities: full range, a narrow band that forces ties, and the extremes.
	function automatic logic signed [spq_pkg::DATA_W-1:0] pick_rank();
		int unsigned sel;
		sel = $urandom_range(2);
		case (sel)
			0: begin
				return $urandom;
			end
			1: begin
				return $signed($urandom_range(6)) - 3;
			end
			default: begin
				case ($urandom_range(3))
					0:       return 32'sh8000_0000;
					1:       return 32'sh7FFF_FFFF;
					2:       return 32'sh0000_0000;
					default: return -32'sd1;
				endcase
			end
		endcase
	endfunction

	// A run of random operations, enqueueing with the given likelihood in percent.
	task automatic offer_mixed(input int unsigned count, input int unsigned enq_pct);
		int unsigned n;
		logic        op;
		for (n = 0; n < count; n++) begin
			op = ($urandom_range(99) < enq_pct) ? spq_pkg::FUNC_ENQ : spq_pkg::FUNC_DEQ;
			offer_beat(op, $urandom, pick_rank());
		end
	endtask

	// A run of one kind of operation with random content.
	task automatic offer_run(input logic op, input int unsigned count);
		int unsigned n;
		for (n = 0; n < count; n++)
			offer_beat(op, $urandom, pick_rank());
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// First phase: sender idles a third of the time, receiver about half.
		tx_idle_pct = 33;
		rx_idle_pct = 53;

		// Directed: empty dequeue, extreme values and priorities, ties served newest first.
		offer_beat(spq_pkg::FUNC_DEQ, 32'sh1234_5678, 32'sh7FFF_FFFF);
		offer_beat(spq_pkg::FUNC_ENQ, 32'sh7FFF_FFFF, 32'sh8000_0000);
		offer_beat(spq_pkg::FUNC_ENQ, 32'sh8000_0000, 32'sh7FFF_FFFF);
		offer_beat(spq_pkg::FUNC_ENQ, 32'sh0000_0000, 32'sh0000_0000);
		offer_beat(spq_pkg::FUNC_ENQ, -32'sd1, -32'sd1);
		offer_beat(spq_pkg::FUNC_ENQ, 32'sh5555_5555, 32'sh0000_0000);
		offer_beat(spq_pkg::FUNC_ENQ, 32'shAAAA_AAAA, 32'sh0000_0000);
		offer_run(spq_pkg::FUNC_DEQ, 7);
		offer_beat(spq_pkg::FUNC_ENQ, 32'sd1, 32'sh7FFF_FFFF);
		offer_beat(spq_pkg::FUNC_ENQ, 32'sd2, 32'sh7FFF_FFFF);
		offer_beat(spq_pkg::FUNC_ENQ, 32'sd3, 32'sh8000_0000);
		offer_beat(spq_pkg::FUNC_ENQ, 32'sd4, 32'sh8000_0000);
		offer_run(spq_pkg::FUNC_DEQ, 5);

		// Receiver holds off while enqueues keep coming, so the block backs up.
		hold_token++;
		offer_run(spq_pkg::FUNC_ENQ, 24);
		offer_mixed(60, 60);
		pause_until_drained();

		// Second phase: the idling swapped round.
		tx_idle_pct = 53;
		rx_idle_pct = 33;
		offer_mixed(60, 40);
		pause_until_drained();

		// Third phase, no idling: fill past full, drain past empty, then a mixed tail.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		offer_run(spq_pkg::FUNC_ENQ, QUEUE_DEPTH + 6);
		offer_run(spq_pkg::FUNC_DEQ, QUEUE_DEPTH + 6);
		offer_mixed(30, 50);

		pause_until_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("sorted_priority_queue_core verification clean");
		else
			$display("sorted_priority_queue_core verification failed");
		$finish;
	end

endmodule
